@@ design/assert_macros.svh @@
// Assertion macros for the design files.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_CLK_ALWAYS(label, prop, msg)
`endif
`endif

@@ design/mme_pkg.sv @@
// Types and constants for the matrix multiply engine.
// No dependencies; imported by matrix_multiply_engine.
package mme_pkg;

    localparam int IDX_W     = 3;
    localparam int VALUE_W   = 16;
    localparam int SUM_W     = 36;
    localparam int DIM_REG_W = 4;
    localparam int CFG_IDX_W = 2;

    // command codes
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd2;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]                op;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [SUM_W-1:0] cell_sum;
        logic                    last;
    } result_t;

    // per-term tag travelling alongside the read data
    typedef struct packed {
        logic             first;
        logic             last_term;
        logic             zero;
        logic             last_cell;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

@@ design/matrix_multiply_engine.sv @@
// Matrix multiply engine: A and B element stores, term sequencer and MAC.
// Depends on mme_pkg and assert_macros.svh.
//
// Load words (op load A / load B) are written into the element stores in the
// cycle they are taken and cause no result, so loads stream one a cycle while
// busy is low. A start word walks the result matrix in row-major order, reading
// one A and one B element per cycle from the two element stores and feeding one
// multiply-accumulate per cycle through the registered read, the product
// register and the accumulator, and busy stays high until the last term has
// been accumulated. Each cell appears on result for one cycle with
// result_strobe high; the receiver cannot stall, so results must be taken when
// shown.
// Dimensions above MAX_DIM act as MAX_DIM; a_rows or b_cols of zero give no
// result, inner_dim of zero gives cells of zero.
`include "assert_macros.svh"

module matrix_multiply_engine #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  mme_pkg::cmd_t                            cmd,
    output logic                                     result_strobe,
    output mme_pkg::result_t                         result,
    input  logic                                     cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [mme_pkg::DIM_REG_W-1:0]            cfg_data
);
    import mme_pkg::*;

    localparam int EW          = (ELEM_WIDTH < VALUE_W) ? ELEM_WIDTH : VALUE_W;
    localparam int PROD_W      = 2 * EW;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [DIM_REG_W-1:0] MAX_DIM_L = DIM_REG_W'(MAX_DIM);

    function automatic logic [DIM_REG_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] d);
        return (d > MAX_DIM_L) ? MAX_DIM_L : d;
    endfunction

    // configuration registers
    logic [DIM_REG_W-1:0] a_rows_reg;
    logic [DIM_REG_W-1:0] inner_dim_reg;
    logic [DIM_REG_W-1:0] b_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            b_cols_reg    <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_A_ROWS:    a_rows_reg    <= cfg_data;
                CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                CFG_B_COLS:    b_cols_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // effective dimensions
    logic [DIM_REG_W-1:0] m_dim, n_dim, p_dim, n_eff;
    assign m_dim = clamp_dim(a_rows_reg);
    assign n_dim = clamp_dim(inner_dim_reg);
    assign p_dim = clamp_dim(b_cols_reg);
    assign n_eff = (n_dim == '0) ? DIM_REG_W'(1) : n_dim;

    // word acceptance and load decode
    logic accept;
    logic in_range;
    logic a_we, b_we;
    logic [ADDR_W-1:0] waddr;

    assign accept   = start && !busy;
    assign in_range = ({1'b0, cmd.row} < MAX_DIM_L) && ({1'b0, cmd.col} < MAX_DIM_L);
    assign a_we     = accept && (cmd.op == OP_LOAD_A) && in_range;
    assign b_we     = accept && (cmd.op == OP_LOAD_B) && in_range;
    assign waddr    = ADDR_W'(cmd.row * MAX_DIM + cmd.col);

    // sequencer
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     i_reg, i_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [DIM_REG_W-1:0] k_wide;
    logic                 issue;
    logic                 k_end, j_end, i_end;
    tag_t                 issue_tag;
    logic [ADDR_W-1:0]    a_raddr, b_raddr;

    assign k_wide = {{(DIM_REG_W-CNT_W){1'b0}}, k_reg};
    assign k_end  = (k_wide == n_eff - DIM_REG_W'(1));
    assign j_end  = ({{(DIM_REG_W-CNT_W){1'b0}}, j_reg} == p_dim - DIM_REG_W'(1));
    assign i_end  = ({{(DIM_REG_W-CNT_W){1'b0}}, i_reg} == m_dim - DIM_REG_W'(1));

    assign a_raddr = ADDR_W'(i_reg * MAX_DIM + k_reg);
    assign b_raddr = ADDR_W'(k_reg * MAX_DIM + j_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        issue      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.op == OP_START) && (m_dim != '0) && (p_dim != '0))
                begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_RUN:
            begin
                issue = 1'b1;
                if (!k_end)
                begin
                    k_next = k_reg + CNT_W'(1);
                end
                else
                begin
                    k_next = '0;
                    if (!j_end)
                    begin
                        j_next = j_reg + CNT_W'(1);
                    end
                    else
                    begin
                        j_next = '0;
                        if (i_end)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next = i_reg + CNT_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        issue_tag.first     = (k_reg == '0);
        issue_tag.last_term = k_end;
        issue_tag.zero      = (n_dim == '0);
        issue_tag.last_cell = i_end && j_end;
        issue_tag.row       = IDX_W'(i_reg);
        issue_tag.col       = IDX_W'(j_reg);
    end

    // element stores, registered read
    logic [EW-1:0] a_mem [STORE_DEPTH];
    logic [EW-1:0] b_mem [STORE_DEPTH];
    logic signed [EW-1:0] a_rdata_reg, b_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[waddr] <= cmd.value[EW-1:0];
        end
        a_rdata_reg <= a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[waddr] <= cmd.value[EW-1:0];
        end
        b_rdata_reg <= b_mem[b_raddr];
    end

    // pipeline control: read stage, product stage
    logic s1_valid_reg, s2_valid_reg;
    tag_t s1_tag_reg, s2_tag_reg;
    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // multiply
    always_ff @(posedge clk)
    begin
        s1_tag_reg <= issue_tag;
        s2_tag_reg <= s1_tag_reg;
        if (s1_tag_reg.zero)
        begin
            prod_reg <= '0;
        end
        else
        begin
            prod_reg <= PROD_W'(a_rdata_reg) * PROD_W'(b_rdata_reg);
        end
    end

    // accumulate and hand out the finished cell
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic                    strobe_reg;
    result_t                 result_reg;

    assign acc_next = (s2_tag_reg.first ? SUM_W'(0) : acc_reg) + SUM_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (s2_valid_reg && s2_tag_reg.last_term)
        begin
            result_reg.out_row  <= s2_tag_reg.row;
            result_reg.out_col  <= s2_tag_reg.col;
            result_reg.cell_sum <= acc_next;
            result_reg.last     <= s2_tag_reg.last_cell;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= s2_valid_reg && s2_tag_reg.last_term;
        end
    end

    assign busy          = (state_reg == ST_RUN) || s1_valid_reg || s2_valid_reg;
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // checks
    `ASSERT_CLK(a_last_alone, result_strobe && result.last |=> !result_strobe, "result word after last cell")
    `ASSERT_CLK(a_no_load_busy, (a_we || b_we) |-> (state_reg == ST_IDLE) && !s1_valid_reg, "store written during a run")
    `ASSERT_CLK(a_k_range, (state_reg == ST_RUN) |-> (k_wide < n_eff), "inner index beyond dimension")
    `ASSERT_CLK(a_start_runs, accept && (cmd.op == OP_START) && (m_dim != '0) && (p_dim != '0) |=> busy, "start word did not begin a run")
    `ASSERT_CLK_ALWAYS(a_reset_quiet, !rst_n |-> !result_strobe, "result word during reset")

endmodule
